[hdl/zlib_stored_block_encoder_unit_assert.svh]
// ============================================================================
// Assertion macros for the zlib stored block encoder
// Shared concurrent assertion forms, clocked and disabled during reset.
// ============================================================================
`ifndef ZLIB_STORED_BLOCK_ENCODER_UNIT_ASSERT_SVH
`define ZLIB_STORED_BLOCK_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ZSBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ZSBE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/zsbe_pkg.sv]
// ============================================================================
// zsbe_pkg
// Types, constants and output select codes of the zlib stored block encoder.
// ============================================================================
`default_nettype none

package zsbe_pkg;

    localparam int BLOCK_BYTES = 32;
    localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int CNT_W = $clog2(BLOCK_BYTES + 1);

    localparam int CMF_VALUE = 8 + (7 << 4);
    localparam int FLG_VALUE = 31 - ((CMF_VALUE * 256) % 31);
    localparam logic [7:0] ZLIB_CMF = 8'(CMF_VALUE);
    localparam logic [7:0] ZLIB_FLG = 8'(FLG_VALUE);

    localparam logic [16:0] ADLER_MOD = 17'd65521;

    typedef logic [3:0] t_out_sel;
    localparam t_out_sel SEL_HDR0  = 4'd0;
    localparam t_out_sel SEL_HDR1  = 4'd1;
    localparam t_out_sel SEL_FLAG0 = 4'd2;
    localparam t_out_sel SEL_FLAG1 = 4'd3;
    localparam t_out_sel SEL_LEN0  = 4'd4;
    localparam t_out_sel SEL_LEN1  = 4'd5;
    localparam t_out_sel SEL_NLEN0 = 4'd6;
    localparam t_out_sel SEL_NLEN1 = 4'd7;
    localparam t_out_sel SEL_DATA  = 4'd8;
    localparam t_out_sel SEL_ADL0  = 4'd9;
    localparam t_out_sel SEL_ADL1  = 4'd10;
    localparam t_out_sel SEL_ADL2  = 4'd11;
    localparam t_out_sel SEL_ADL3  = 4'd12;

    typedef struct packed {
        logic     accept;
        logic     write;
        logic     push;
        t_out_sel sel;
        logic     last;
        logic     done;
        logic     rd_clr;
        logic     rd_issue;
        logic     fill_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic will_fill;
        logic fill_zero;
        logic rd_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[hdl/zsbe_in_if.sv]
// ============================================================================
// zsbe_in_if
// Input request channel: one payload byte and its stream markers.
// ============================================================================
`default_nettype none

interface zsbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input end_of_stream, output ready);
endinterface

`default_nettype wire

[hdl/zsbe_out_if.sv]
// ============================================================================
// zsbe_out_if
// Output request channel: one byte of the zlib stream with its markers.
// ============================================================================
`default_nettype none

interface zsbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;

    modport source (output valid, output out_byte, output last_of_run,
                    output stream_done, input ready);
    modport sink (input valid, input out_byte, input last_of_run,
                  input stream_done, output ready);
endinterface

`default_nettype wire

[hdl/zsbe_datapath.sv]
// ============================================================================
// zsbe_datapath
// Block store, fill count, Adler-32 sums, read pointer and output register.
// ============================================================================
`default_nettype none

`include "zlib_stored_block_encoder_unit_assert.svh"

module zsbe_datapath
    import zsbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_data_byte,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_stream_done
);

    logic [7:0]       r_store [BLOCK_BYTES];
    logic [7:0]       r_rd_data;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_rd_ptr;
    logic [15:0]      r_low;
    logic [15:0]      r_high;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_done;

    logic [16:0] w_sum_low;
    logic [16:0] w_sum_high;
    logic [15:0] n_low;
    logic [15:0] n_high;
    logic [15:0] w_len;
    logic [7:0]  w_sel_byte;

    always_comb begin
        w_sum_low  = {1'b0, r_low} + 17'(i_data_byte);
        n_low      = (w_sum_low >= ADLER_MOD) ? 16'(w_sum_low - ADLER_MOD) : w_sum_low[15:0];
        w_sum_high = {1'b0, r_high} + {1'b0, n_low};
        n_high     = (w_sum_high >= ADLER_MOD) ? 16'(w_sum_high - ADLER_MOD)
                                               : w_sum_high[15:0];
    end

    assign w_len = 16'(r_fill);

    always_comb begin
        unique case (i_cmd.sel)
            SEL_HDR0:  w_sel_byte = ZLIB_CMF;
            SEL_HDR1:  w_sel_byte = ZLIB_FLG;
            SEL_FLAG0: w_sel_byte = 8'h00;
            SEL_FLAG1: w_sel_byte = 8'h01;
            SEL_LEN0:  w_sel_byte = w_len[7:0];
            SEL_LEN1:  w_sel_byte = w_len[15:8];
            SEL_NLEN0: w_sel_byte = ~w_len[7:0];
            SEL_NLEN1: w_sel_byte = ~w_len[15:8];
            SEL_DATA:  w_sel_byte = r_rd_data;
            SEL_ADL0:  w_sel_byte = r_high[15:8];
            SEL_ADL1:  w_sel_byte = r_high[7:0];
            SEL_ADL2:  w_sel_byte = r_low[15:8];
            SEL_ADL3:  w_sel_byte = r_low[7:0];
            default:   w_sel_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_cmd.write) begin
            r_store[r_fill[IDX_W-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_store[r_rd_ptr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rd_ptr <= '0;
            r_low    <= 16'd1;
            r_high   <= 16'd0;
        end else begin
            if (i_cmd.accept && i_cmd.write) begin
                r_fill <= r_fill + CNT_W'(1);
                r_low  <= n_low;
                r_high <= n_high;
            end else if (i_cmd.fill_clr) begin
                r_fill <= '0;
            end
            if (i_cmd.rd_clr || i_cmd.fill_clr) begin
                r_rd_ptr <= '0;
            end else if (i_cmd.rd_issue) begin
                r_rd_ptr <= r_rd_ptr + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_byte <= w_sel_byte;
            r_out_last <= i_cmd.last;
            r_out_done <= i_cmd.done;
        end
    end

    assign o_status.will_fill = (r_fill == CNT_W'(BLOCK_BYTES - 1));
    assign o_status.fill_zero = (r_fill == '0);
    assign o_status.rd_done   = (r_rd_ptr == r_fill);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_stream_done = r_out_done;

    `ZSBE_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(BLOCK_BYTES), "Fill count exceeds the block size.")
    `ZSBE_ASSERT_IMP(a_rd_bound, i_clk, i_rst_n, 1'b1, r_rd_ptr <= r_fill, "Read pointer runs past the filled bytes.")
    `ZSBE_ASSERT_IMP(a_adler_range, i_clk, i_rst_n, 1'b1, (17'(r_low) < ADLER_MOD) && (17'(r_high) < ADLER_MOD), "Adler-32 sum out of range.")
    `ZSBE_ASSERT_IMP(a_push_free, i_clk, i_rst_n, i_cmd.push, !r_out_valid || i_out_ready, "Output register overwritten while held.")
    `ZSBE_ASSERT_NXT(a_done_last, i_clk, i_rst_n, i_cmd.push && i_cmd.done, r_out_valid && r_out_done && r_out_last, "Final byte not marked as last.")

endmodule

`default_nettype wire

[hdl/zsbe_controller.sv]
// ============================================================================
// zsbe_controller
// Sequencer for header, stored block framing, data readout and trailer.
// ============================================================================
`default_nettype none

module zsbe_controller
    import zsbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_byte_present,
    input  wire logic       i_end_of_stream,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HDR0  = 4'd1;
    localparam logic [3:0] S_HDR1  = 4'd2;
    localparam logic [3:0] S_FLAG  = 4'd3;
    localparam logic [3:0] S_LEN0  = 4'd4;
    localparam logic [3:0] S_LEN1  = 4'd5;
    localparam logic [3:0] S_NLEN0 = 4'd6;
    localparam logic [3:0] S_NLEN1 = 4'd7;
    localparam logic [3:0] S_DRD   = 4'd8;
    localparam logic [3:0] S_DOUT  = 4'd9;
    localparam logic [3:0] S_ADL0  = 4'd10;
    localparam logic [3:0] S_ADL1  = 4'd11;
    localparam logic [3:0] S_ADL2  = 4'd12;
    localparam logic [3:0] S_ADL3  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_hdr_done;
    logic       n_hdr_done;
    logic       r_finished;
    logic       n_finished;
    logic       r_flush;
    logic       n_flush;
    logic       r_end;
    logic       n_end;

    always_comb begin
        n_state    = r_state;
        n_hdr_done = r_hdr_done;
        n_finished = r_finished;
        n_flush    = r_flush;
        n_end      = r_end;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !r_finished) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.write  = i_byte_present;
                    n_flush      = i_byte_present && i_status.will_fill;
                    n_end        = i_end_of_stream;
                    if (!r_hdr_done) begin
                        n_state = S_HDR0;
                    end else if (n_flush || n_end) begin
                        n_state = S_FLAG;
                    end
                end
            end
            S_HDR0: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_HDR0;
                    n_state    = S_HDR1;
                end
            end
            S_HDR1: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_HDR1;
                    o_cmd.last = !r_flush && !r_end;
                    n_hdr_done = 1'b1;
                    n_state    = (r_flush || r_end) ? S_FLAG : S_IDLE;
                end
            end
            S_FLAG: begin
                if (i_status.out_free) begin
                    o_cmd.push   = 1'b1;
                    o_cmd.sel    = r_flush ? SEL_FLAG0 : SEL_FLAG1;
                    o_cmd.rd_clr = 1'b1;
                    n_state      = S_LEN0;
                end
            end
            S_LEN0: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_LEN0;
                    n_state    = S_LEN1;
                end
            end
            S_LEN1: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_LEN1;
                    n_state    = S_NLEN0;
                end
            end
            S_NLEN0: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_NLEN0;
                    n_state    = S_NLEN1;
                end
            end
            S_NLEN1: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_NLEN1;
                    n_state    = i_status.fill_zero ? S_ADL0 : S_DRD;
                end
            end
            S_DRD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_DOUT;
            end
            S_DOUT: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_DATA;
                    o_cmd.last = r_flush && i_status.rd_done && !r_end;
                    if (!i_status.rd_done) begin
                        n_state = S_DRD;
                    end else begin
                        o_cmd.fill_clr = 1'b1;
                        if (r_flush) begin
                            n_flush = 1'b0;
                            n_state = r_end ? S_FLAG : S_IDLE;
                        end else begin
                            n_state = S_ADL0;
                        end
                    end
                end
            end
            S_ADL0: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_ADL0;
                    n_state    = S_ADL1;
                end
            end
            S_ADL1: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_ADL1;
                    n_state    = S_ADL2;
                end
            end
            S_ADL2: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_ADL2;
                    n_state    = S_ADL3;
                end
            end
            S_ADL3: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.sel  = SEL_ADL3;
                    o_cmd.last = 1'b1;
                    o_cmd.done = 1'b1;
                    n_finished = 1'b1;
                    n_end      = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hdr_done <= 1'b0;
            r_finished <= 1'b0;
            r_flush    <= 1'b0;
            r_end      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hdr_done <= n_hdr_done;
            r_finished <= n_finished;
            r_flush    <= n_flush;
            r_end      <= n_end;
        end
    end

endmodule

`default_nettype wire

[hdl/zlib_stored_block_encoder_unit.sv]
// ============================================================================
// zlib_stored_block_encoder_unit
// Byte stream to zlib stream encoder in stored mode with Adler-32 trailer.
// ============================================================================
// The input channel i_in carries one request per cycle at most: a payload
// byte with byte_present, and end_of_stream to close the stream. The output
// channel o_out delivers the zlib stream one byte per request, with
// last_of_run on the final byte caused by an input request and stream_done
// on the final Adler-32 byte.
// A request that only adds a byte to a block that does not fill is taken in
// the idle state and produces no output. The first request adds the two
// header bytes. A request that fills the block, or ends the stream, holds
// the input until its bytes are out: five framing bytes have a state each,
// and every data byte a read state and an output state, as the block store
// is read through a register. The end of stream adds the final block and
// four trailer bytes. The output byte sits in a register, so a new byte
// can be loaded in the same cycle the previous one is taken. When the
// receiver stalls, the sequencer waits with that register full. After the
// stream is done every further request is accepted and dropped until reset.
// Reset is synchronous and active low: the Adler-32 sums return to one and
// zero and the block buffer is empty.
// ============================================================================
`default_nettype none

module zlib_stored_block_encoder_unit
    import zsbe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    zsbe_in_if.sink    i_in,
    zsbe_out_if.source o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    zsbe_controller u_controller (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .o_in_ready      (w_in_ready),
        .i_byte_present  (i_in.byte_present),
        .i_end_of_stream (i_in.end_of_stream),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    zsbe_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in.data_byte),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_byte    (o_out.out_byte),
        .o_last_of_run (o_out.last_of_run),
        .o_stream_done (o_out.stream_done)
    );

    assign i_in.ready = w_in_ready;

endmodule

`default_nettype wire

[tb/sv/tb_zlib_stored_block_encoder_unit.sv]
// ============================================================================
// tb_zlib_stored_block_encoder_unit
// Self-checking bench for the stored mode zlib encoder. A directed opening and
// a long random byte stream are sent as one zlib stream. A local model of the
// header, stored block framing and Adler-32 trailer predicts every output
// byte with its markers. Both channels idle at random.
// ============================================================================
`default_nettype none

module tb_zlib_stored_block_encoder_unit
    import zsbe_pkg::*;
();

    localparam logic [7:0] CMF_BYTE = 8'(8 + (7 << 4));
    localparam logic [7:0] FLG_BYTE = 8'(31 - ((int'(CMF_BYTE) << 8) % 31));
    localparam int MOD_ADLER = 65521;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_stream;
    } t_zlib_request;

    typedef struct {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
    } t_zlib_out_byte;

    logic i_clk;
    logic i_rst_n;

    zsbe_in_if  in_req ();
    zsbe_out_if out_req ();

    zlib_stored_block_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_req),
        .o_out   (out_req)
    );

    t_zlib_request  pending_requests[$];
    t_zlib_out_byte zlib_bytes_due[$];

    logic [7:0] block_copy [BLOCK_BYTES];
    int         block_fill;
    int         adler_a;
    int         adler_b;
    logic       header_sent;
    logic       stream_closed;

    int   gen_fill;
    int   requests_driven;
    int   bytes_received;
    logic failed;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic due_push(input logic [7:0] value);
        t_zlib_out_byte entry;
        entry.out_byte    = value;
        entry.last_of_run = 1'b0;
        entry.stream_done = 1'b0;
        zlib_bytes_due.push_back(entry);
    endtask

    task automatic stored_block_out(input logic is_final);
        logic [15:0] len;
        logic [15:0] nlen;
        len  = 16'(block_fill);
        nlen = 16'hFFFF ^ len;
        due_push({7'd0, is_final});
        due_push(len[7:0]);
        due_push(len[15:8]);
        due_push(nlen[7:0]);
        due_push(nlen[15:8]);
        for (int i = 0; i < block_fill && i < BLOCK_BYTES; i++) begin
            due_push(block_copy[i]);
        end
        block_fill = 0;
    endtask

    task automatic zlib_encode_request(input t_zlib_request rq);
        int             start_size;
        logic [31:0]    adler;
        t_zlib_out_byte tail;
        start_size = zlib_bytes_due.size();
        if (stream_closed) begin
            return;
        end
        if (!header_sent) begin
            due_push(CMF_BYTE);
            due_push(FLG_BYTE);
            header_sent = 1'b1;
        end
        if (rq.byte_present) begin
            if (block_fill < BLOCK_BYTES) begin
                block_copy[block_fill] = rq.data_byte;
            end
            block_fill++;
            adler_a += int'(rq.data_byte);
            if (adler_a >= MOD_ADLER) begin
                adler_a -= MOD_ADLER;
            end
            adler_b += adler_a;
            if (adler_b >= MOD_ADLER) begin
                adler_b -= MOD_ADLER;
            end
            if (block_fill >= BLOCK_BYTES) begin
                stored_block_out(1'b0);
            end
        end
        if (rq.end_of_stream) begin
            adler = {adler_b[15:0], adler_a[15:0]};
            stored_block_out(1'b1);
            due_push(adler[31:24]);
            due_push(adler[23:16]);
            due_push(adler[15:8]);
            due_push(adler[7:0]);
            tail = zlib_bytes_due.pop_back();
            tail.stream_done = 1'b1;
            zlib_bytes_due.push_back(tail);
            stream_closed = 1'b1;
        end
        if (zlib_bytes_due.size() > start_size) begin
            tail = zlib_bytes_due.pop_back();
            tail.last_of_run = 1'b1;
            zlib_bytes_due.push_back(tail);
        end
    endtask

    task automatic queue_request(input logic [7:0] value, input logic present,
                                 input logic eos);
        t_zlib_request rq;
        rq.data_byte     = value;
        rq.byte_present  = present;
        rq.end_of_stream = eos;
        pending_requests.push_back(rq);
        if (present) begin
            gen_fill = (gen_fill + 1) % BLOCK_BYTES;
        end
    endtask

    // Driver: a new request is presented only once the previous one is taken.
    always @(posedge i_clk) begin
        t_zlib_request rq;
        logic          gap;
        if (!i_rst_n) begin
            in_req.valid <= 1'b0;
        end else if (!in_req.valid || in_req.ready) begin
            gap = ($urandom_range(99) < 26)
                  && !(requests_driven >= 120 && requests_driven < 200);
            if (pending_requests.size() > 0 && !gap) begin
                rq = pending_requests.pop_front();
                in_req.data_byte     <= rq.data_byte;
                in_req.byte_present  <= rq.byte_present;
                in_req.end_of_stream <= rq.end_of_stream;
                in_req.valid         <= 1'b1;
                zlib_encode_request(rq);
                requests_driven++;
            end else begin
                in_req.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each taken output byte against the oldest prediction.
    always @(posedge i_clk) begin
        t_zlib_out_byte want;
        if (i_rst_n) begin
            if (out_req.valid && out_req.ready) begin
                bytes_received++;
                if (zlib_bytes_due.size() == 0) begin
                    $error("unexpected output byte %h", out_req.out_byte);
                    failed = 1'b1;
                end else begin
                    want = zlib_bytes_due.pop_front();
                    if (out_req.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, out_req.out_byte);
                        failed = 1'b1;
                    end
                    if (out_req.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last_of_run, out_req.last_of_run);
                        failed = 1'b1;
                    end
                    if (out_req.stream_done !== want.stream_done) begin
                        $error("stream_done: expected %b, actual %b",
                               want.stream_done, out_req.stream_done);
                        failed = 1'b1;
                    end
                end
            end
            out_req.ready <= !($urandom_range(99) < 26)
                             || (bytes_received >= 150 && bytes_received < 270);
        end
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [7:0] value;
        i_rst_n              = 1'b0;
        in_req.valid         = 1'b0;
        in_req.data_byte     = 8'h00;
        in_req.byte_present  = 1'b0;
        in_req.end_of_stream = 1'b0;
        out_req.ready        = 1'b0;
        block_fill           = 0;
        adler_a              = 1;
        adler_b              = 0;
        header_sent          = 1'b0;
        stream_closed        = 1'b0;
        gen_fill             = 0;
        requests_driven      = 0;
        bytes_received       = 0;
        failed               = 1'b0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            block_copy[i] = 8'h00;
        end

        // The first request carries no byte and only brings out the header.
        queue_request(8'h00, 1'b0, 1'b0);
        // A request with nothing to say after the header.
        queue_request(8'hFF, 1'b0, 1'b0);
        queue_request(8'h00, 1'b1, 1'b0);
        queue_request(8'hFF, 1'b1, 1'b0);
        queue_request(8'h01, 1'b1, 1'b0);
        queue_request(8'h80, 1'b1, 1'b0);
        queue_request(8'h7F, 1'b1, 1'b0);
        queue_request(8'hAA, 1'b0, 1'b0);
        queue_request(8'h55, 1'b1, 1'b0);
        for (int i = 0; i < 10; i++) begin
            queue_request(8'hFF, 1'b1, 1'b0);
        end

        for (int i = 0; i < 150; i++) begin
            if ($urandom_range(99) < 4 * 25 / 10) begin
                queue_request(8'($urandom), 1'b0, 1'b0);
            end else begin
                if ($urandom_range(3) != 0) begin
                    value = 8'($urandom_range(255, 240));
                end else begin
                    value = 8'($urandom);
                end
                queue_request(value, 1'b1, 1'b0);
            end
        end

        // The ending request also fills the block.
        while (gen_fill != BLOCK_BYTES - 1) begin
            queue_request(8'($urandom), 1'b1, 1'b0);
        end
        queue_request(8'($urandom), 1'b1, 1'b1);

        // Requests after the end of the stream are dropped.
        queue_request(8'($urandom), 1'b1, 1'b0);
        queue_request(8'($urandom), 1'b0, 1'b1);
        queue_request(8'($urandom), 1'b1, 1'b1);
        queue_request(8'($urandom), 1'b0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || in_req.valid) begin
            @(posedge i_clk);
        end
        while (zlib_bytes_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
